// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the curve evaluator checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define CCPE_ASSERT(lbl, clk_i, rst_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) prop) else $error(msg);

// clocked assertion that also watches the reset cycles
`define CCPE_ASSERT_NORST(lbl, clk_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/core/ccpe_pkg.sv -----
// ----------------------------------------------------------------------------
// ccpe_pkg
// types, widths and codes shared by the cubic curve point evaluator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ccpe_pkg;

  // default number of steps per segment
  localparam int SEGMENT_STEPS_DEF = 100;

  // field widths
  localparam int STEP_W    = 7;
  localparam int COORD_W   = 16;
  localparam int OUT_W     = 20;
  localparam int TENSION_W = 16;

  // internal datapath widths, sized for the largest step count a 7-bit index allows
  localparam int SQ_W    = 2 * STEP_W;        // j^2, u^2
  localparam int WGT_W   = 21;                // basis weights, up to steps^3
  localparam int OPD_W   = COORD_W + 1;       // operands and point differences
  localparam int PROD_W  = WGT_W + 1 + OPD_W; // weight times operand
  localparam int SUM_W   = PROD_W + 2;        // sum of four products
  localparam int K_W     = TENSION_W + 1;     // tangent scale 1.0 - tension
  localparam int T_SPLIT = 20;                // low half of the tangent sum
  localparam int PP_W    = SUM_W - T_SPLIT + K_W;
  localparam int MAIN_SH = 15;                // Q1.15 alignment of point terms
  localparam int NUM_W   = 58;
  localparam int QSH     = 11;                // rounding shift
  localparam int MQ_W    = NUM_W - QSH;
  localparam int MP_W    = OUT_W + WGT_W;     // offset dividend
  localparam int SPLIT_W = 21;                // dividend split for reciprocal
  localparam int RCP_W   = OUT_W + 2;
  localparam int PH_W    = MP_W - SPLIT_W + RCP_W;
  localparam int PL_W    = SPLIT_W + RCP_W;
  localparam int QS_W    = MP_W + RCP_W;

  // register reset and constants
  localparam logic [TENSION_W-1:0]    TENSION_RESET = 16'd8192;
  localparam logic signed [K_W-1:0]   TENSION_ONE   = 17'sd16384;
  localparam logic signed [OUT_W-1:0] OUT_MAX       = 20'sh7FFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN       = 20'sh80000;

  // curve modes
  localparam logic [1:0] OP_BEZIER     = 2'd0;
  localparam logic [1:0] OP_HERMITE    = 2'd1;
  localparam logic [1:0] OP_CARDINAL   = 2'd2;
  localparam logic [1:0] OP_BEZIER_ALT = 2'd3;

  // request payload
  typedef struct packed {
    logic [1:0]                op;
    logic signed [COORD_W-1:0] pt_a_x;
    logic signed [COORD_W-1:0] pt_a_y;
    logic signed [COORD_W-1:0] pt_b_x;
    logic signed [COORD_W-1:0] pt_b_y;
    logic signed [COORD_W-1:0] pt_c_x;
    logic signed [COORD_W-1:0] pt_c_y;
    logic signed [COORD_W-1:0] pt_d_x;
    logic signed [COORD_W-1:0] pt_d_y;
    logic [STEP_W-1:0]         step_index;
  } ccpe_req_t;

  // result payload
  typedef struct packed {
    logic signed [OUT_W-1:0] curve_x;
    logic signed [OUT_W-1:0] curve_y;
    logic                    clipped;
  } ccpe_pt_t;

endpackage

// ----- rtl/core/cubic_curve_point_eval.sv -----
// ----------------------------------------------------------------------------
// cubic_curve_point_eval
// Evaluates one point of a cubic Bezier, Hermite or cardinal segment per
// request at t = step_index / SEGMENT_STEPS (index clamped to the step count)
// and returns it in 1/16 pixel units, rounded half up and saturated per axis
// with clipped set on saturation. A request is accepted every cycle while
// ctrl_stall is low; the depth is set by the weight products,
// the tension product and the reciprocal divide by SEGMENT_STEPS^3, each
// cut into registered stages. The twelve stages close up around bubbles, so
// ctrl_stall rises only when every stage holds a point and pt_stall is high.
// The tension register is written through cfg with cfg_ready always high; the user
// must write it only while no request is in flight, which the block itself leaves unchecked.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cubic_curve_point_eval
  import ccpe_pkg::*;
#(
  parameter int SEGMENT_STEPS = SEGMENT_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ctrl_valid,
  output logic                 ctrl_stall,
  input  ccpe_req_t            ctrl_data,
  output logic                 pt_valid,
  input  logic                 pt_stall,
  output ccpe_pt_t             pt_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [TENSION_W-1:0] cfg_data
);

  // segment constants
  localparam int DEN    = SEGMENT_STEPS * SEGMENT_STEPS * SEGMENT_STEPS;
  localparam int DEN_W  = $clog2(DEN + 1);
  localparam int RCP_SH = OUT_W + DEN_W;
  localparam logic [63:0]              RCP     = (64'd1 << RCP_SH) / 64'(DEN);
  localparam logic [RCP_W-1:0]         RCP_V   = RCP_W'(RCP);
  localparam logic [STEP_W-1:0]        STEPS   = STEP_W'(SEGMENT_STEPS);
  localparam logic [WGT_W-1:0]         DEN_V   = WGT_W'(DEN);
  localparam logic signed [NUM_W-1:0]  BIAS    = NUM_W'(DEN) << (QSH - 1);
  localparam logic signed [MQ_W-1:0]   SAT_LIM = MQ_W'(DEN) << (OUT_W - 1);
  localparam int NSTG = 12;

  // pipeline control: a stage loads when it or some stage after it is free, or when pt_stall is low
  logic [NSTG:1] v;
  logic [NSTG:1] en;

  for (genvar g = 1; g <= NSTG; g++) begin : g_en
    assign en[g] = !(&v[NSTG:g]) || !pt_stall;
  end

  assign ctrl_stall = !en[1];
  assign pt_valid   = v[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= ctrl_valid;
      end
      for (int i = 2; i <= NSTG; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // tension register
  logic [TENSION_W-1:0] tension;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tension <= TENSION_RESET;
    end else if (cfg_valid) begin
      tension <= cfg_data;
    end
  end

  // stage 1: clamp the step, squares of j and u
  logic [STEP_W-1:0]         j_cl;
  logic [STEP_W-1:0]         u_cl;
  logic signed [COORD_W-1:0] pin [2][4];
  logic [1:0]                s1_op;
  logic [STEP_W-1:0]         s1_j;
  logic [STEP_W-1:0]         s1_u;
  logic [SQ_W-1:0]           s1_j2;
  logic [SQ_W-1:0]           s1_u2;
  logic signed [COORD_W-1:0] s1_pt [2][4];

  always_comb begin
    j_cl = (ctrl_data.step_index > STEPS) ? STEPS : ctrl_data.step_index;
    u_cl = STEPS - j_cl;
    pin[0][0] = ctrl_data.pt_a_x;
    pin[1][0] = ctrl_data.pt_a_y;
    pin[0][1] = ctrl_data.pt_b_x;
    pin[1][1] = ctrl_data.pt_b_y;
    pin[0][2] = ctrl_data.pt_c_x;
    pin[1][2] = ctrl_data.pt_c_y;
    pin[0][3] = ctrl_data.pt_d_x;
    pin[1][3] = ctrl_data.pt_d_y;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_op <= ctrl_data.op;
      s1_j  <= j_cl;
      s1_u  <= u_cl;
      s1_j2 <= SQ_W'(j_cl) * SQ_W'(j_cl);
      s1_u2 <= SQ_W'(u_cl) * SQ_W'(u_cl);
      s1_pt <= pin;
    end
  end

  // stage 2: cubic monomials j^3, u^3, j^2 u, j u^2
  logic [1:0]                s2_op;
  logic signed [COORD_W-1:0] s2_pt [2][4];
  logic [WGT_W-1:0]          s2_j3;
  logic [WGT_W-1:0]          s2_u3;
  logic [WGT_W-1:0]          s2_j2u;
  logic [WGT_W-1:0]          s2_ju2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_op  <= s1_op;
      s2_pt  <= s1_pt;
      s2_j3  <= WGT_W'(s1_j2) * WGT_W'(s1_j);
      s2_u3  <= WGT_W'(s1_u2) * WGT_W'(s1_u);
      s2_j2u <= WGT_W'(s1_j2) * WGT_W'(s1_u);
      s2_ju2 <= WGT_W'(s1_u2) * WGT_W'(s1_j);
    end
  end

  // stage 3: basis weights and operands for the selected mode
  logic [WGT_W-1:0]          b1;
  logic [WGT_W-1:0]          b2;
  logic [WGT_W-1:0]          h1;
  logic [WGT_W-1:0]          h3;
  logic signed [OPD_W-1:0]   ex [2][4];
  logic [WGT_W-1:0]          w_sel [4];
  logic signed [OPD_W-1:0]   p_sel [2][4];
  logic                      card_sel;
  logic [WGT_W-1:0]          s3_w [4];
  logic signed [OPD_W-1:0]   s3_p [2][4];
  logic                      s3_card;

  always_comb begin
    b1 = s2_ju2 + (s2_ju2 << 1);
    b2 = s2_j2u + (s2_j2u << 1);
    h1 = s2_u3 + b1;
    h3 = s2_j3 + b2;
    for (int ax = 0; ax < 2; ax++) begin
      for (int i = 0; i < 4; i++) begin
        ex[ax][i] = OPD_W'(s2_pt[ax][i]);
      end
    end
    unique case (s2_op) inside
      OP_HERMITE: begin
        w_sel    = '{h1, h3, s2_ju2, s2_j2u};
        card_sel = 1'b0;
        for (int ax = 0; ax < 2; ax++) begin
          p_sel[ax] = '{ex[ax][0], ex[ax][1], ex[ax][2], -ex[ax][3]};
        end
      end
      OP_CARDINAL: begin
        // tangent terms get the tension scale in stage 6
        w_sel    = '{h1, h3, s2_ju2, s2_j2u};
        card_sel = 1'b1;
        for (int ax = 0; ax < 2; ax++) begin
          p_sel[ax] = '{ex[ax][1], ex[ax][2], ex[ax][2] - ex[ax][0],
                        ex[ax][1] - ex[ax][3]};
        end
      end
      OP_BEZIER, OP_BEZIER_ALT: begin
        w_sel    = '{s2_u3, b1, b2, s2_j3};
        card_sel = 1'b0;
        for (int ax = 0; ax < 2; ax++) begin
          p_sel[ax] = '{ex[ax][0], ex[ax][1], ex[ax][2], ex[ax][3]};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_w    <= w_sel;
      s3_p    <= p_sel;
      s3_card <= card_sel;
    end
  end

  // stage 4: weight times operand, eight products
  logic signed [PROD_W-1:0] s4_m [2][4];
  logic                     s4_card;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_card <= s3_card;
      for (int ax = 0; ax < 2; ax++) begin
        for (int i = 0; i < 4; i++) begin
          s4_m[ax][i] <= PROD_W'($signed({1'b0, s3_w[i]})) * PROD_W'(s3_p[ax][i]);
        end
      end
    end
  end

  // stage 5: point sum and tangent sum
  logic signed [SUM_W-1:0] pair_lo [2];
  logic signed [SUM_W-1:0] pair_hi [2];
  logic signed [SUM_W-1:0] s5_main [2];
  logic signed [SUM_W-1:0] s5_tang [2];

  always_comb begin
    for (int ax = 0; ax < 2; ax++) begin
      pair_lo[ax] = SUM_W'(s4_m[ax][0]) + SUM_W'(s4_m[ax][1]);
      pair_hi[ax] = SUM_W'(s4_m[ax][2]) + SUM_W'(s4_m[ax][3]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int ax = 0; ax < 2; ax++) begin
        s5_main[ax] <= s4_card ? pair_lo[ax] : pair_lo[ax] + pair_hi[ax];
        s5_tang[ax] <= s4_card ? pair_hi[ax] : '0;
      end
    end
  end

  // stage 6: tangent sum times (1 - tension), split in two halves
  logic signed [K_W-1:0]   kval;
  logic signed [NUM_W-1:0] s6_mainb [2];
  logic signed [PP_W-1:0]  s6_hk [2];
  logic signed [PP_W-1:0]  s6_lk [2];

  assign kval = TENSION_ONE - K_W'($signed(tension));

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int ax = 0; ax < 2; ax++) begin
        s6_mainb[ax] <= (NUM_W'(s5_main[ax]) <<< MAIN_SH) + BIAS;
        s6_hk[ax]    <= PP_W'($signed(s5_tang[ax][SUM_W-1:T_SPLIT])) * PP_W'(kval);
        s6_lk[ax]    <= PP_W'($signed({1'b0, s5_tang[ax][T_SPLIT-1:0]})) * PP_W'(kval);
      end
    end
  end

  // stage 7: full numerator, rounding shift
  logic signed [NUM_W-1:0] num [2];
  logic signed [MQ_W-1:0]  s7_mq [2];

  always_comb begin
    for (int ax = 0; ax < 2; ax++) begin
      num[ax] = s6_mainb[ax] + (NUM_W'(s6_hk[ax]) <<< T_SPLIT) + NUM_W'(s6_lk[ax]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int ax = 0; ax < 2; ax++) begin
        s7_mq[ax] <= MQ_W'(num[ax] >>> QSH);
      end
    end
  end

  // stage 8: saturation test, offset dividend into the positive range
  logic [MP_W-1:0] s8_mp [2];
  logic [1:0]      s8_sh;
  logic [1:0]      s8_sl;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      for (int ax = 0; ax < 2; ax++) begin
        s8_sh[ax] <= s7_mq[ax] >= SAT_LIM;
        s8_sl[ax] <= s7_mq[ax] < -SAT_LIM;
        s8_mp[ax] <= MP_W'(s7_mq[ax] + SAT_LIM);
      end
    end
  end

  // stage 9: reciprocal partial products
  logic [PH_W-1:0] s9_ph [2];
  logic [PL_W-1:0] s9_pl [2];
  logic [MP_W-1:0] s9_mp [2];
  logic [1:0]      s9_sh;
  logic [1:0]      s9_sl;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_mp <= s8_mp;
      s9_sh <= s8_sh;
      s9_sl <= s8_sl;
      for (int ax = 0; ax < 2; ax++) begin
        s9_ph[ax] <= PH_W'(s8_mp[ax][MP_W-1:SPLIT_W]) * PH_W'(RCP_V);
        s9_pl[ax] <= PL_W'(s8_mp[ax][SPLIT_W-1:0]) * PL_W'(RCP_V);
      end
    end
  end

  // stage 10: quotient estimate, low by at most one
  logic [QS_W-1:0]  qs [2];
  logic [OUT_W-1:0] s10_qe [2];
  logic [MP_W-1:0]  s10_mp [2];
  logic [1:0]       s10_sh;
  logic [1:0]       s10_sl;

  always_comb begin
    for (int ax = 0; ax < 2; ax++) begin
      qs[ax] = (QS_W'(s9_ph[ax]) << SPLIT_W) + QS_W'(s9_pl[ax]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s10_mp <= s9_mp;
      s10_sh <= s9_sh;
      s10_sl <= s9_sl;
      for (int ax = 0; ax < 2; ax++) begin
        s10_qe[ax] <= OUT_W'(qs[ax] >> RCP_SH);
      end
    end
  end

  // stage 11: estimate times divisor
  logic [MP_W-1:0]  s11_qd [2];
  logic [OUT_W-1:0] s11_qe [2];
  logic [MP_W-1:0]  s11_mp [2];
  logic [1:0]       s11_sh;
  logic [1:0]       s11_sl;

  always_ff @(posedge clk) begin
    if (en[11]) begin
      s11_qe <= s10_qe;
      s11_mp <= s10_mp;
      s11_sh <= s10_sh;
      s11_sl <= s10_sl;
      for (int ax = 0; ax < 2; ax++) begin
        s11_qd[ax] <= MP_W'(s10_qe[ax]) * MP_W'(DEN_V);
      end
    end
  end

  // stage 12: quotient correction, remove offset, saturate
  logic [MP_W-1:0]         rem [2];
  logic [OUT_W-1:0]        qfix [2];
  logic signed [OUT_W-1:0] coord [2];
  ccpe_pt_t                pt_q;

  always_comb begin
    for (int ax = 0; ax < 2; ax++) begin
      rem[ax]  = s11_mp[ax] - s11_qd[ax];
      qfix[ax] = s11_qe[ax] + OUT_W'(rem[ax] >= MP_W'(DEN_V));
      if (s11_sh[ax]) begin
        coord[ax] = OUT_MAX;
      end else if (s11_sl[ax]) begin
        coord[ax] = OUT_MIN;
      end else begin
        coord[ax] = {~qfix[ax][OUT_W-1], qfix[ax][OUT_W-2:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[12]) begin
      pt_q.curve_x <= coord[0];
      pt_q.curve_y <= coord[1];
      pt_q.clipped <= |(s11_sh | s11_sl);
    end
  end

  assign pt_data = pt_q;

endmodule

// ----- rtl/core/ccpe_checker.sv -----
// ----------------------------------------------------------------------------
// ccpe_checker
// port-level checks for the cubic curve point evaluator, bound to the top
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ccpe_checker
  import ccpe_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     ctrl_stall,
  input logic     pt_valid,
  input logic     pt_stall,
  input ccpe_pt_t pt_data
);

  // a coordinate at either rail
  logic at_rail;
  // a point waiting under stall
  logic pt_held;

  assign at_rail = (pt_data.curve_x == OUT_MAX) || (pt_data.curve_x == OUT_MIN) ||
                   (pt_data.curve_y == OUT_MAX) || (pt_data.curve_y == OUT_MIN);
  assign pt_held = pt_valid && pt_stall;

  // a stalled point stays put
  `CCPE_ASSERT(a_pt_hold, clk, rst, pt_held |=> pt_valid && $stable(pt_data), "point not held")

  // clipped only comes with a saturated coordinate
  `CCPE_ASSERT(a_clip_rail, clk, rst, pt_valid && pt_data.clipped |-> at_rail, "clip off rail")

  // requests are held back only when the output is full and stalled
  `CCPE_ASSERT(a_stall_full, clk, rst, ctrl_stall |-> pt_held, "request stalled with room")

  // reset empties the pipeline
  `CCPE_ASSERT_NORST(a_reset_empty, clk, rst |=> !pt_valid, "point right after reset")

endmodule

bind cubic_curve_point_eval ccpe_checker u_ccpe_checker (.*);
